// ===== hdl/ptrk_pkg.sv =====
package ptrk_pkg;

	// Field widths shared by the ports and the datapath.
	localparam int unsigned COORD_W   = 16;
	localparam int unsigned SIZE_W    = 13;
	localparam int unsigned CENTER_W  = SIZE_W - 1;
	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned BTN_W     = 3;
	localparam int unsigned CODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;

	// Packed stream widths, padded to whole bytes.
	localparam int unsigned IN_FIELDS_W  = 4 * COORD_W + BTN_W;
	localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = 8 * COORD_W + 3 * CODE_W;
	localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Quotient bits produced by the divider; one bit per cycle.
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Item function codes.
	localparam logic [FUNC_W-1:0] FUNC_POLL       = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET_NORM   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RECENTER   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RECENTER_X = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SENS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 3'd4;

	// Button transition codes.
	localparam logic [CODE_W-1:0] BTN_IDLE     = 2'd0;
	localparam logic [CODE_W-1:0] BTN_PRESSED  = 2'd1;
	localparam logic [CODE_W-1:0] BTN_HELD     = 2'd2;
	localparam logic [CODE_W-1:0] BTN_RELEASED = 2'd3;

	// Divide jobs: cursor offset X/Y, then motion X/Y.
	localparam logic [1:0] JOB_POS_X  = 2'd0;
	localparam logic [1:0] JOB_POS_Y  = 2'd1;
	localparam logic [1:0] JOB_MOVE_X = 2'd2;
	localparam logic [1:0] JOB_MOVE_Y = 2'd3;

	// Reset values.
	localparam logic signed [COORD_W-1:0] SENS_RESET   = 16'sd256;
	localparam logic [SIZE_W-1:0]         WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0]         HEIGHT_RESET = 13'd480;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_MOVE,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_RESULT
	} state_t;

endpackage

// ===== hdl/pointer_cursor_tracker_unit.sv =====
// Channel   Direction  Handshake               Payload
// s_*       in         s_tvalid / s_tready     s_tdata: motion, buttons, targets; s_tuser: func
// m_*       out        m_tvalid / m_tready     m_tdata: cursor, deltas, normalized, buttons
// cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A poll runs two multiplies, one clamp step and four divides on the one bit-per-cycle
// divider. Clear transitions runs two divides, set normalized two multiplies, and the
// other functions go straight to the result. A new item is taken only in the idle state.
// arst_n clears the cursor to the center of the reset client size and all control state.
// A result waits in the output register while the next item is taken; a stalled output
// holds the sequencer before it overwrites that register. cfg_ready is always high.
module pointer_cursor_tracker_unit
	import ptrk_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata from bit 0: raw_dx, raw_dy, button_bits, target_norm_x, target_norm_y, zeros
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: func
	input  logic [FUNC_W-1:0]     s_tuser,
	// m_tdata from bit 0: cursor_x, cursor_y, scaled_dx, scaled_dy, pos_norm_x,
	// pos_norm_y, move_norm_x, move_norm_y, left_code, right_code, middle_code, zeros
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_W-1:0]    cfg_data
);

	// Configuration registers.
	logic signed [COORD_W-1:0] sens_x_q, sens_y_q;
	logic [SIZE_W-1:0]         width_q, height_q;
	logic                      wrap_q;

	// Tracker state.
	logic signed [COORD_W-1:0] pos_x_q, pos_y_q, npos_x_q, npos_y_q;
	logic [BTN_W-1:0]          cur_btn_q, prev_btn_q;
	logic [3*CODE_W-1:0]       codes_q;

	// Working registers of the current item.
	state_t                    state_q, state_d;
	logic [FUNC_W-1:0]         func_q;
	logic signed [COORD_W-1:0] raw_dx_q, raw_dy_q, tgt_x_q, tgt_y_q;
	logic [BTN_W-1:0]          btn_in_q;
	logic signed [COORD_W-1:0] sdx_q, sdy_q, mnx_q, mny_q;
	logic                      axis_q;
	logic signed [33:0]        prod_q;
	logic [1:0]                job_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [CENTER_W-1:0]       rem_q, dc_q;
	logic [DIV_STEPS-1:0]      nq_q;
	logic                      neg_q, ovf_q;

	// Output register.
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     out_data_q;

	// Handshake strobes.
	logic in_fire, out_load;

	logic [CENTER_W-1:0] cx, cy;
	assign cx = width_q[SIZE_W-1:1];
	assign cy = height_q[SIZE_W-1:1];

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [33:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_axis(
		input logic signed [16:0] sum,
		input logic [SIZE_W-1:0]  size,
		input logic               wrap
	);
		logic signed [16:0] v;
		logic signed [16:0] lim;
		lim = $signed({4'b0, size});
		if (wrap) begin
			v = sum;
			if (sum > 17'sd32767) begin
				v = 17'sd32767;
			end else if (sum < -17'sd32768) begin
				v = -17'sd32768;
			end
		end else begin
			v = (sum < 17'sd0) ? 17'sd0 : sum;
			if (v >= lim) begin
				v = lim - 17'sd1;
			end
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_norm(input logic signed [15:0] n);
		logic signed [COORD_W-1:0] r;
		if (n > 16'sd16384) begin
			r = 16'sd16384;
		end else if (n < -16'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = n;
		end
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] btn_code(input logic c, input logic p);
		logic [CODE_W-1:0] r;
		if (c) begin
			r = p ? BTN_HELD : BTN_PRESSED;
		end else begin
			r = p ? BTN_RELEASED : BTN_IDLE;
		end
		return r;
	endfunction

	// Multiplier operands: gain times raw motion for a poll, center times
	// normalized target for set normalized.
	logic signed [16:0] mul_a, mul_b;
	always_comb begin
		if (func_q == FUNC_POLL) begin
			mul_a = axis_q ? {raw_dy_q[15], raw_dy_q} : {raw_dx_q[15], raw_dx_q};
			mul_b = axis_q ? {sens_y_q[15], sens_y_q} : {sens_x_q[15], sens_x_q};
		end else begin
			mul_a = $signed({5'b0, (axis_q ? cy : cx)});
			mul_b = axis_q ? {tgt_y_q[15], tgt_y_q} : {tgt_x_q[15], tgt_x_q};
		end
	end

	// Truncating shifts of the registered product toward zero.
	logic signed [33:0] shr8, shr14;
	logic signed [16:0] set_pos;
	always_comb begin
		shr8    = (prod_q + (prod_q[33] ? 34'sd255 : 34'sd0)) >>> 8;
		shr14   = (prod_q + (prod_q[33] ? 34'sd16383 : 34'sd0)) >>> 14;
		set_pos = $signed({5'b0, (axis_q ? cy : cx)}) + shr14[16:0];
	end

	// Cursor plus scaled motion, per axis.
	logic signed [16:0] sum_x, sum_y;
	assign sum_x = {pos_x_q[15], pos_x_q} + {sdx_q[15], sdx_q};
	assign sum_y = {pos_y_q[15], pos_y_q} + {sdy_q[15], sdy_q};

	// Divider job setup: dividend, its sign and magnitude, and the overflow check.
	logic signed [16:0]  div_v;
	logic [16:0]         div_abs;
	logic [CENTER_W-1:0] div_c;
	logic                div_ovf;
	always_comb begin
		unique case (job_q)
			JOB_POS_X:  div_v = {pos_x_q[15], pos_x_q} - $signed({5'b0, cx});
			JOB_POS_Y:  div_v = {pos_y_q[15], pos_y_q} - $signed({5'b0, cy});
			JOB_MOVE_X: div_v = {sdx_q[15], sdx_q};
			default:    div_v = {sdy_q[15], sdy_q};
		endcase
		div_c   = job_q[0] ? cy : cx;
		div_abs = div_v[16] ? 17'(-div_v) : 17'(div_v);
		// The quotient exceeds its 17 bits when the top dividend part reaches the divisor.
		div_ovf = div_abs[16:3] >= {2'b0, div_c};
	end

	// One restoring divide step.
	logic [CENTER_W:0] div_t;
	logic              div_ge;
	logic [CENTER_W:0] div_sub;
	always_comb begin
		div_t   = {rem_q, nq_q[DIV_STEPS-1]};
		div_ge  = div_t >= {1'b0, dc_q};
		div_sub = div_t - {1'b0, dc_q};
	end

	// Saturated, signed quotient of the finished job.
	logic signed [COORD_W-1:0] div_res;
	always_comb begin
		if (dc_q == '0) begin
			div_res = '0;
		end else if (neg_q) begin
			if (ovf_q || nq_q > 17'd32768) begin
				div_res = 16'sh8000;
			end else begin
				div_res = 16'(-$signed({1'b0, nq_q[15:0]}));
			end
		end else begin
			if (ovf_q || nq_q > 17'd32767) begin
				div_res = 16'sh7FFF;
			end else begin
				div_res = nq_q[15:0];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == FUNC_POLL || s_tuser == FUNC_SET_NORM) begin
						state_d = ST_MUL;
					end else if (s_tuser == FUNC_CLEAR) begin
						state_d = ST_MOVE;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: begin
				if (!axis_q) begin
					state_d = ST_MUL;
				end else if (func_q == FUNC_POLL) begin
					state_d = ST_MOVE;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_MOVE:     state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (div_cnt_q == '0) begin
					state_d = ST_DIV_STORE;
				end
			end
			ST_DIV_STORE: begin
				if (job_q == JOB_MOVE_Y || (func_q != FUNC_POLL && job_q == JOB_POS_Y)) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_DIV_LOAD;
				end
			end
			ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs of the sequencer.
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		in_fire   = s_tvalid && (state_q == ST_IDLE);
		out_load  = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_x_q <= SENS_RESET;
			sens_y_q <= SENS_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			wrap_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SENS_X: sens_x_q <= cfg_data;
				CFG_SENS_Y: sens_y_q <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				CFG_WRAP:   wrap_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Tracker state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= $signed({4'b0, WIDTH_RESET[SIZE_W-1:1]});
			pos_y_q    <= $signed({4'b0, HEIGHT_RESET[SIZE_W-1:1]});
			npos_x_q   <= '0;
			npos_y_q   <= '0;
			cur_btn_q  <= '0;
			prev_btn_q <= '0;
			codes_q    <= '0;
			func_q     <= FUNC_POLL;
			axis_q     <= 1'b0;
			job_q      <= JOB_POS_X;
			div_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						func_q <= s_tuser;
						axis_q <= 1'b0;
						job_q  <= JOB_POS_X;
						unique case (s_tuser)
							FUNC_RECENTER: begin
								pos_x_q  <= $signed({4'b0, cx});
								pos_y_q  <= $signed({4'b0, cy});
								npos_x_q <= '0;
								npos_y_q <= '0;
							end
							FUNC_RECENTER_X: pos_x_q <= $signed({4'b0, cx});
							default: ;
						endcase
					end
				end
				ST_SCALE: begin
					axis_q <= ~axis_q;
					if (func_q == FUNC_SET_NORM) begin
						if (axis_q) begin
							pos_y_q  <= set_pos[COORD_W-1:0];
							npos_y_q <= tgt_y_q;
						end else begin
							pos_x_q  <= set_pos[COORD_W-1:0];
							npos_x_q <= tgt_x_q;
						end
					end
				end
				ST_MOVE: begin
					pos_x_q    <= clamp_axis(sum_x, width_q, wrap_q);
					pos_y_q    <= clamp_axis(sum_y, height_q, wrap_q);
					prev_btn_q <= cur_btn_q;
					if (func_q == FUNC_POLL) begin
						cur_btn_q <= btn_in_q;
						codes_q   <= {btn_code(btn_in_q[2], cur_btn_q[2]),
						              btn_code(btn_in_q[1], cur_btn_q[1]),
						              btn_code(btn_in_q[0], cur_btn_q[0])};
					end else begin
						codes_q <= '0;
					end
				end
				ST_DIV_LOAD: div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
				ST_DIV_RUN:  div_cnt_q <= div_cnt_q - 1'b1;
				ST_DIV_STORE: begin
					job_q <= job_q + 2'd1;
					unique case (job_q)
						JOB_POS_X: npos_x_q <= div_res;
						JOB_POS_Y: npos_y_q <= div_res;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Payload registers: item fields, product, divider and results.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_dx_q <= s_tdata[15:0];
			raw_dy_q <= s_tdata[31:16];
			btn_in_q <= s_tdata[34:32];
			tgt_x_q  <= clamp_norm(s_tdata[50:35]);
			tgt_y_q  <= clamp_norm(s_tdata[66:51]);
			sdx_q    <= '0;
			sdy_q    <= '0;
			mnx_q    <= '0;
			mny_q    <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_SCALE && func_q == FUNC_POLL) begin
			if (axis_q) begin
				sdy_q <= sat16(shr8);
			end else begin
				sdx_q <= sat16(shr8);
			end
		end
		if (state_q == ST_DIV_LOAD) begin
			rem_q <= div_abs[14:3];
			nq_q  <= {div_abs[2:0], 14'b0};
			neg_q <= div_v[16];
			ovf_q <= div_ovf;
			dc_q  <= div_c;
		end
		if (state_q == ST_DIV_RUN) begin
			rem_q <= div_ge ? div_sub[CENTER_W-1:0] : div_t[CENTER_W-1:0];
			nq_q  <= {nq_q[DIV_STEPS-2:0], div_ge};
		end
		if (state_q == ST_DIV_STORE) begin
			if (job_q == JOB_MOVE_X) begin
				mnx_q <= div_res;
			end else if (job_q == JOB_MOVE_Y) begin
				mny_q <= div_res;
			end
		end
		if (out_load) begin
			out_data_q <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, codes_q,
			               mny_q, mnx_q, npos_y_q, npos_x_q,
			               sdy_q, sdx_q, pos_y_q, pos_x_q};
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	// Without wrap mode the clamped cursor lies inside the client area.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_LOAD && job_q == JOB_POS_X && !wrap_q && width_q != '0)
		|-> (pos_x_q >= 16'sd0 && pos_x_q < $signed({3'b0, width_q})))
		else $error("cursor X outside client area after clamp");

	// The divider remainder stays below the divisor on a job that does not overflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_RUN && !ovf_q && dc_q != '0) |-> (rem_q < dc_q))
		else $error("divider remainder not below divisor");

	// A new result appears only from the result state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_RESULT))
		else $error("result valid raised outside the result state");

	// An accepted item always leaves the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("item transfer did not start the sequencer");

endmodule
